// File: src/ipv6_text_address_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IPv6 text address parser
// ----------------------------------------------------------------------------
`ifndef IPV6_TEXT_ADDRESS_PARSER_TOP_MACROS_SVH
`define IPV6_TEXT_ADDRESS_PARSER_TOP_MACROS_SVH

// Checked only while out of reset.
`define IPV6P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IPV6P_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/ipv6p_pkg.sv
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Types and constants shared by the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

    localparam int NUM_GROUPS = 8;
    localparam int GROUP_W    = 16;

    typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] t_groups;

    typedef struct packed {
        t_groups    groups;
        logic [3:0] index;
        logic       after_sep;
        logic       seen_comp;
        logic [2:0] comp_pos;
        logic [1:0] err;
    } t_parse_st;

    localparam t_parse_st PARSE_RESET = '0;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_DOUBLE_COMP = 2'd1;
    localparam logic [1:0] STATUS_BAD_SEP     = 2'd2;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] LETTER_BASE  = 8'd10;

endpackage

// File: src/ipv6p_consume.sv
// ----------------------------------------------------------------------------
// ipv6p_consume
// Next parse state for one character: digit accumulation or separator handling.
// ----------------------------------------------------------------------------
module ipv6p_consume
    import ipv6p_pkg::*;
(
    input  t_parse_st  i_st,
    input  logic [7:0] i_char_code,
    output t_parse_st  o_st
);

    logic [7:0]  digit;
    logic        is_digit;
    logic [3:0]  next_index;
    logic [15:0] cur_group;

    always_comb begin
        is_digit = 1'b1;
        if (i_char_code >= CHAR_0 && i_char_code <= CHAR_9) begin
            digit = i_char_code - CHAR_0;
        end else if (i_char_code >= CHAR_LOWER_A && i_char_code <= CHAR_LOWER_Z) begin
            digit = i_char_code - CHAR_LOWER_A + LETTER_BASE;
        end else if (i_char_code >= CHAR_UPPER_A && i_char_code <= CHAR_UPPER_Z) begin
            digit = i_char_code - CHAR_UPPER_A + LETTER_BASE;
        end else begin
            digit    = 8'd0;
            is_digit = 1'b0;
        end
    end

    assign next_index = i_st.index + 4'd1;
    assign cur_group  = i_st.groups[i_st.index[2:0]];

    always_comb begin
        o_st = i_st;
        // hold everything once an error is latched
        if (i_st.err == STATUS_OK) begin
            if (is_digit) begin
                o_st.after_sep = 1'b0;
                // letters past f carry into the upper nibbles
                o_st.groups[i_st.index[2:0]] = {cur_group[11:0], 4'h0} + {8'h00, digit};
            end else begin
                o_st.index = next_index;
                if (i_st.after_sep && i_st.seen_comp) begin
                    o_st.err = STATUS_DOUBLE_COMP;
                end else begin
                    if (i_st.after_sep) begin
                        o_st.seen_comp = 1'b1;
                        o_st.comp_pos  = i_st.index[2:0];
                    end
                    o_st.after_sep = 1'b1;
                    if (i_char_code != CHAR_COLON || next_index >= 4'(NUM_GROUPS)) begin
                        o_st.err = STATUS_BAD_SEP;
                    end
                end
            end
        end
    end

endmodule

// File: src/ipv6p_assemble.sv
// ----------------------------------------------------------------------------
// ipv6p_assemble
// Expand the double colon and pack the eight groups into two 64-bit halves.
// ----------------------------------------------------------------------------
module ipv6p_assemble
    import ipv6p_pkg::*;
(
    input  t_parse_st   i_st,
    output logic [63:0] o_addr_high,
    output logic [63:0] o_addr_low
);

    t_groups addr;

    always_comb begin
        logic [4:0] src_sum;
        logic [2:0] src;
        addr    = '0;
        src_sum = '0;
        src     = '0;
        for (int j = 0; j < NUM_GROUPS; j++) begin
            if (!i_st.seen_comp) begin
                addr[j] = i_st.groups[j];
            end else if (3'(j) < i_st.comp_pos) begin
                addr[j] = i_st.groups[j];
            end else begin
                // groups after the gap slide to the tail
                src_sum = 5'(j) + {2'b00, i_st.index[2:0]} + 5'd1;
                src     = src_sum[2:0];
                if (src_sum[3] && src > i_st.comp_pos) begin
                    addr[j] = i_st.groups[src];
                end
            end
        end
        if (i_st.err != STATUS_OK) begin
            addr = '0;
        end
    end

    assign o_addr_high = {addr[0], addr[1], addr[2], addr[3]};
    assign o_addr_low  = {addr[4], addr[5], addr[6], addr[7]};

endmodule

// File: src/ipv6_text_address_parser_top.sv
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_top
// Path: each character is held in the input register; a last character then writes the result register.
// Throughput: one character per cycle, unless a last character waits on a stalled result register.
// Reset: synchronous, active low; clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_top
    import ipv6p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_addr_high,
    output logic [63:0] o_addr_low,
    output logic [1:0]  o_status
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    t_parse_st   r_st;
    t_parse_st   n_st;
    logic        r_out_valid;
    logic [63:0] r_out_high;
    logic [63:0] r_out_low;
    logic [1:0]  r_out_status;
    logic [63:0] n_out_high;
    logic [63:0] n_out_low;
    logic        out_free;
    logic        advance;
    logic        in_accept;

    ipv6p_consume u_consume (
        .i_st        (r_st),
        .i_char_code (r_in_char),
        .o_st        (n_st)
    );

    ipv6p_assemble u_assemble (
        .i_st        (n_st),
        .o_addr_high (n_out_high),
        .o_addr_low  (n_out_low)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // a non-last character never needs the result register
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_st        <= PARSE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_st <= r_in_last ? PARSE_RESET : n_st;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last;
        end
        if (advance && r_in_last) begin
            r_out_high   <= n_out_high;
            r_out_low    <= n_out_low;
            r_out_status <= n_st.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_addr_high = r_out_high;
    assign o_addr_low  = r_out_low;
    assign o_status    = r_out_status;

endmodule

// File: src/ipv6p_checker.sv
// ----------------------------------------------------------------------------
// ipv6p_checker
// Port-level checks on the result channel of the IPv6 text address parser.
// ----------------------------------------------------------------------------
`include "ipv6_text_address_parser_top_macros.svh"

module ipv6p_checker
    import ipv6p_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_stall,
    input logic        o_out_valid,
    input logic [63:0] o_addr_high,
    input logic [63:0] o_addr_low,
    input logic [1:0]  o_status
);

    `IPV6P_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_addr_high) && $stable(o_addr_low) && $stable(o_status), "stalled result word changed")

    `IPV6P_ASSERT(a_err_zero, o_out_valid && o_status != STATUS_OK |-> o_addr_high == 64'd0 && o_addr_low == 64'd0, "error result carries a non-zero address")

    `IPV6P_ASSERT(a_status_code, o_out_valid |-> o_status == STATUS_OK || o_status == STATUS_DOUBLE_COMP || o_status == STATUS_BAD_SEP, "undefined status code")

    `IPV6P_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

bind ipv6_text_address_parser_top ipv6p_checker u_ipv6p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_addr_high (o_addr_high),
    .o_addr_low  (o_addr_low),
    .o_status    (o_status)
);

// File: sim/ipv6_text_address_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_top_test
// Feeds address text one character per word and checks every parsed address.
// A predictor tracks the group store, separator and compression flags. For
// each string it computes the 128-bit address and status, which are compared
// with what the parser returns. Both handshakes idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_top_test;
    import ipv6p_pkg::*;

    localparam int TARGET_ITEMS   = 1400;
    localparam int CALM_ITEMS     = 120;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_text_word;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
        logic [1:0]  status;
    } t_parsed_addr;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_last      = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_addr_high;
    logic [63:0] o_addr_low;
    logic [1:0]  o_status;

    t_text_word   text_q[$];
    t_parsed_addr pending_addrs[$];
    t_text_word   next_word;

    // parse state of the predictor
    logic [15:0] grp_acc [NUM_GROUPS];
    logic [3:0]  grp_idx;
    logic        sep_open;
    logic        comp_seen;
    logic [2:0]  comp_at;
    logic [1:0]  fault;

    int   chars_taken = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;
    logic calm        = 1'b0;
    int   idle_cycles = 0;
    int   mismatches  = 0;

    ipv6_text_address_parser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_addr_high (o_addr_high),
        .o_addr_low  (o_addr_low),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_parse();
        for (int k = 0; k < NUM_GROUPS; k++) begin
            grp_acc[k] = '0;
        end
        grp_idx   = '0;
        sep_open  = 1'b0;
        comp_seen = 1'b0;
        comp_at   = '0;
        fault     = STATUS_OK;
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic fin);
        logic [15:0]  digit;
        logic         is_digit;
        logic [15:0]  addr [NUM_GROUPS];
        int           gi;
        int           gp;
        int           k;
        t_parsed_addr want;
        digit    = '0;
        is_digit = 1'b1;
        if (fault == STATUS_OK) begin
            if (ch >= CHAR_0 && ch <= CHAR_9) begin
                digit = 16'(ch - CHAR_0);
            end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
                digit = 16'(ch - CHAR_LOWER_A + LETTER_BASE);
            end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
                digit = 16'(ch - CHAR_UPPER_A + LETTER_BASE);
            end else begin
                is_digit = 1'b0;
            end
            if (is_digit) begin
                sep_open = 1'b0;
                grp_acc[grp_idx[2:0]] = {grp_acc[grp_idx[2:0]][11:0], 4'h0} + digit;
            end else begin
                grp_idx = grp_idx + 4'd1;
                if (sep_open && comp_seen) begin
                    fault = STATUS_DOUBLE_COMP;
                end else begin
                    // a separator straight after another opens the compression
                    if (sep_open) begin
                        comp_seen = 1'b1;
                        comp_at   = 3'(grp_idx - 4'd1);
                    end
                    sep_open = 1'b1;
                    if (ch != CHAR_COLON || grp_idx >= 4'(NUM_GROUPS)) begin
                        fault = STATUS_BAD_SEP;
                    end
                end
            end
        end
        if (fin) begin
            for (k = 0; k < NUM_GROUPS; k++) begin
                addr[k] = '0;
            end
            if (fault == STATUS_OK) begin
                if (comp_seen) begin
                    gi = int'(grp_idx[2:0]);
                    gp = int'(comp_at);
                    for (k = 0; k < gp; k++) begin
                        addr[k] = grp_acc[k];
                    end
                    // move the groups after the compression to the tail
                    for (k = gp + 1; k <= gi; k++) begin
                        addr[(k + 7 - gi) & 7] = grp_acc[k & 7];
                    end
                end else begin
                    for (k = 0; k < NUM_GROUPS; k++) begin
                        addr[k] = grp_acc[k];
                    end
                end
            end
            want.high   = {addr[0], addr[1], addr[2], addr[3]};
            want.low    = {addr[4], addr[5], addr[6], addr[7]};
            want.status = fault;
            pending_addrs.push_back(want);
            clear_parse();
        end
    endtask

    task automatic check_addr(input logic [63:0] high, input logic [63:0] low,
                              input logic [1:0] status);
        t_parsed_addr want;
        if (pending_addrs.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected address: high %h low %h status %0d",
                         high, low, status);
            end
            mismatches++;
        end else begin
            want = pending_addrs.pop_front();
            if (high !== want.high || low !== want.low || status !== want.status) begin
                if (mismatches < 10) begin
                    $display("address mismatch: expected high %h low %h status %0d",
                             want.high, want.low, want.status);
                    $display("                  actual   high %h low %h status %0d",
                             high, low, status);
                end
                mismatches++;
            end
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic fin);
        t_text_word w;
        w.ch  = ch;
        w.fin = fin;
        text_q.push_back(w);
    endtask

    task automatic push_string(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k], k == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_digit();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return 8'(CHAR_0 + $urandom_range(0, 9));
        end else if (sel < 6) begin
            return 8'(CHAR_LOWER_A + $urandom_range(0, 5));
        end else if (sel < 8) begin
            return 8'(CHAR_UPPER_A + $urandom_range(0, 5));
        end else if (sel == 8) begin
            return 8'(CHAR_LOWER_A + $urandom_range(6, 25));
        end
        return 8'(CHAR_UPPER_A + $urandom_range(6, 25));
    endfunction

    task automatic add_group(ref logic [7:0] txt[$]);
        int ndig;
        // now and then run past four digits so the group wraps
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        for (int k = 0; k < ndig; k++) begin
            txt.push_back(rand_digit());
        end
    endtask

    task automatic add_address();
        logic [7:0] txt[$];
        int         kind;
        int         n_groups;
        int         comp_pos;
        int         n;
        logic       use_comp;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            use_comp = 1'($urandom_range(0, 1));
            if (use_comp) begin
                n_groups = $urandom_range(0, 7);
                comp_pos = $urandom_range(0, n_groups);
            end else begin
                n_groups = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : NUM_GROUPS;
                comp_pos = -1;
            end
            for (int g = 0; g <= n_groups; g++) begin
                if (g == comp_pos) begin
                    txt.push_back(CHAR_COLON);
                    txt.push_back(CHAR_COLON);
                end else if (g > 0 && g < n_groups) begin
                    txt.push_back(CHAR_COLON);
                end
                if (g < n_groups) begin
                    add_group(txt);
                end
            end
            // break a share of the well-formed strings
            if (kind >= 7) begin
                case ($urandom_range(0, 3))
                    0: begin
                        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        txt.push_back(CHAR_COLON);
                        add_group(txt);
                    end
                    2: begin
                        txt.push_back(CHAR_COLON);
                        txt.push_back(CHAR_COLON);
                        add_group(txt);
                    end
                    default: begin
                        txt.push_back(CHAR_COLON);
                        n = $urandom_range(1, 3);
                        for (int k = 0; k < n; k++) begin
                            txt.push_back(8'($urandom_range(0, 255)));
                        end
                    end
                endcase
            end
        end
        for (int k = 0; k < txt.size(); k++) begin
            push_char(txt[k], k == txt.size() - 1);
        end
    endtask

    // driver: predict on every accepted word, then offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
            calm       <= 1'b0;
        end else begin
            calm <= (text_q.size() <= CALM_ITEMS);
            if (i_in_valid && !o_in_stall) begin
                parse_char(i_char_code, i_last);
                chars_taken <= chars_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    i_in_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end else if (text_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    i_in_valid <= 1'b0;
                    gap_left   <= $urandom_range(0, 3);
                end else begin
                    next_word = text_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_char_code <= next_word.ch;
                    i_last      <= next_word.fin;
                end
            end
        end
    end

    // monitor: check accepted addresses and drive the output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_addr(o_addr_high, o_addr_low, o_status);
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else if (!hold_done && chars_taken >= HOLD_AFTER) begin
                // hold off long enough for the parser to back up its input
                i_out_stall <= 1'b1;
                hold_left   <= HOLD_CYCLES - 1;
                hold_done   <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= stall_left - 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_parse();
        // compression at the start, letters past f, a wrapping group
        push_string("::1");
        push_string("fF::Zg");
        push_string("12345");
        // leading single colon, then a second double colon
        push_string(":1");
        push_string("1::2::");
        // top byte as a separator, characters after the error, a lone zero byte
        push_char(8'h31, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h32, 1'b1);
        push_char(8'h00, 1'b1);
        while (text_q.size() < TARGET_ITEMS) begin
            add_address();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        while (pending_addrs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
